>>> src/ssup_pkg.sv
// Shared types and constants for the servo tick supervisor.
package ssup_pkg;

    localparam int CNT_W     = 16;
    localparam int POS_W     = 32;
    localparam int GEAR_W    = 15;
    localparam int CHECK_W   = 13;

    localparam logic [GEAR_W-1:0]  MIN_DIVIDER   = GEAR_W'(2);
    localparam logic [GEAR_W-1:0]  RESET_DIVIDER = GEAR_W'(10);
    localparam logic [CHECK_W-1:0] CHECK_LIMIT   = CHECK_W'(5000);

    typedef struct packed {
        logic             servo_enable;
        logic             fault_pin_high;
        logic             overcurrent_event;
        logic [CNT_W-1:0] cmd_count;
        logic [CNT_W-1:0] encoder_count;
        logic             delay_a_load;
        logic             delay_b_load;
        logic [CNT_W-1:0] delay_load_value;
    } t_tick_in;

    typedef struct packed {
        logic delay_a_busy;
        logic delay_b_busy;
        logic overcurrent_flag;
        logic fault_led_clear;
    } t_fault_status;

    typedef struct packed {
        logic             servo_tick;
        logic             resynced;
        logic             servo_active;
        logic [POS_W-1:0] command_position;
        logic [POS_W-1:0] feedback_position;
    } t_servo_status;

endpackage

>>> src/ssup_fault_timers.sv
// Delay timers and periodic overcurrent latch check.
module ssup_fault_timers
    import ssup_pkg::*;
(
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_adv,
    input  t_tick_in      i_item,
    output t_fault_status o_status
);

    logic [CNT_W-1:0]   r_delay_a, n_delay_a;
    logic [CNT_W-1:0]   r_delay_b, n_delay_b;
    logic [CHECK_W-1:0] r_check, n_check;
    logic               r_latch, n_latch;
    logic               check_hit;
    logic               cleared;

    always_comb begin
        n_delay_a = (r_delay_a != '0) ? r_delay_a - CNT_W'(1) : r_delay_a;
        n_delay_b = (r_delay_b != '0) ? r_delay_b - CNT_W'(1) : r_delay_b;
        if (i_item.delay_a_load) begin
            n_delay_a = i_item.delay_load_value;
        end
        if (i_item.delay_b_load) begin
            n_delay_b = i_item.delay_load_value;
        end

        check_hit = r_check > CHECK_LIMIT;
        n_check   = check_hit ? '0 : r_check + CHECK_W'(1);
        cleared   = check_hit && i_item.fault_pin_high && r_latch;
        // event wins over a clear in the same tick
        n_latch   = i_item.overcurrent_event || (r_latch && !cleared);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_delay_a <= '0;
            r_delay_b <= '0;
            r_check   <= '0;
            r_latch   <= 1'b0;
        end else if (i_adv) begin
            r_delay_a <= n_delay_a;
            r_delay_b <= n_delay_b;
            r_check   <= n_check;
            r_latch   <= n_latch;
        end
    end

    assign o_status.delay_a_busy     = n_delay_a != '0;
    assign o_status.delay_b_busy     = n_delay_b != '0;
    assign o_status.overcurrent_flag = n_latch;
    assign o_status.fault_led_clear  = cleared;

endmodule

>>> src/ssup_servo_step.sv
// Servo divider, enable tracking and position accumulators.
module ssup_servo_step
    import ssup_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_adv,
    input  t_tick_in          i_item,
    input  logic [GEAR_W-1:0] i_divider,
    output t_servo_status     o_status
);

    logic [GEAR_W-1:0] r_gear, n_gear;
    logic              r_enabled, n_enabled;
    logic [CNT_W-1:0]  r_last_cmd, n_last_cmd;
    logic [CNT_W-1:0]  r_last_enc, n_last_enc;
    logic [POS_W-1:0]  r_cmd_acc, n_cmd_acc;
    logic [POS_W-1:0]  r_fb_acc, n_fb_acc;

    logic [GEAR_W-1:0] div_eff;
    logic [GEAR_W-1:0] gear_inc;
    logic              step;
    logic              first_en;
    logic [CNT_W-1:0]  cmd_sample;
    logic [CNT_W-1:0]  prev_cmd;
    logic [CNT_W-1:0]  prev_enc;
    logic [CNT_W-1:0]  d_cmd;
    logic [CNT_W-1:0]  d_enc;
    logic [POS_W-1:0]  cmd_base;
    logic [POS_W-1:0]  fb_base;

    always_comb begin
        div_eff  = (i_divider < MIN_DIVIDER) ? MIN_DIVIDER : i_divider;
        gear_inc = r_gear + GEAR_W'(1);
        step     = gear_inc >= div_eff;
        n_gear   = step ? '0 : gear_inc;

        // first enabled step: take command from encoder, restart from zero
        first_en   = step && i_item.servo_enable && !r_enabled;
        cmd_sample = first_en ? i_item.encoder_count : i_item.cmd_count;
        prev_cmd   = first_en ? '0 : r_last_cmd;
        prev_enc   = first_en ? '0 : r_last_enc;
        cmd_base   = first_en ? '0 : r_cmd_acc;
        fb_base    = first_en ? '0 : r_fb_acc;
        d_cmd      = cmd_sample - prev_cmd;
        d_enc      = i_item.encoder_count - prev_enc;

        n_enabled  = r_enabled;
        n_last_cmd = r_last_cmd;
        n_last_enc = r_last_enc;
        n_cmd_acc  = r_cmd_acc;
        n_fb_acc   = r_fb_acc;
        if (step) begin
            n_enabled = i_item.servo_enable;
            if (i_item.servo_enable) begin
                n_cmd_acc  = cmd_base + {{(POS_W-CNT_W){d_cmd[CNT_W-1]}}, d_cmd};
                n_fb_acc   = fb_base + {{(POS_W-CNT_W){d_enc[CNT_W-1]}}, d_enc};
                n_last_cmd = cmd_sample;
                n_last_enc = i_item.encoder_count;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gear     <= '0;
            r_enabled  <= 1'b0;
            r_last_cmd <= '0;
            r_last_enc <= '0;
            r_cmd_acc  <= '0;
            r_fb_acc   <= '0;
        end else if (i_adv) begin
            r_gear     <= n_gear;
            r_enabled  <= n_enabled;
            r_last_cmd <= n_last_cmd;
            r_last_enc <= n_last_enc;
            r_cmd_acc  <= n_cmd_acc;
            r_fb_acc   <= n_fb_acc;
        end
    end

    assign o_status.servo_tick        = step;
    assign o_status.resynced          = first_en;
    assign o_status.servo_active      = n_enabled;
    assign o_status.command_position  = n_cmd_acc;
    assign o_status.feedback_position = n_fb_acc;

endmodule

>>> src/servo_tick_supervisor_top.sv
// Top level of the servo tick supervisor: input and result registers around the tick logic.
// One item per base tick. Each accepted item is registered, processed in a single pass through
// the timer, fault check and servo step logic, and its result lands in the output register;
// a result is offered once its item has passed the input register and the result register. The
// block takes a new item every cycle, also while a finished result waits for the consumer; the
// input stalls only when both the input register and the result register are full and the
// consumer is not ready. servo_divider is taken as at least 2 and should be written only while
// no item is in flight.
module servo_tick_supervisor_top
    import ssup_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_cfg_we,
    input  logic [GEAR_W-1:0]       i_cfg_wdata,
    input  logic                    i_in_valid,
    output logic                    o_in_ready,
    input  logic                    i_servo_enable,
    input  logic                    i_fault_pin_high,
    input  logic                    i_overcurrent_event,
    input  logic [CNT_W-1:0]        i_cmd_count,
    input  logic [CNT_W-1:0]        i_encoder_count,
    input  logic                    i_delay_a_load,
    input  logic                    i_delay_b_load,
    input  logic [CNT_W-1:0]        i_delay_load_value,
    output logic                    o_out_valid,
    input  logic                    i_out_ready,
    output logic                    o_servo_tick,
    output logic                    o_resynced,
    output logic                    o_servo_active,
    output logic signed [POS_W-1:0] o_command_position,
    output logic signed [POS_W-1:0] o_feedback_position,
    output logic                    o_overcurrent_flag,
    output logic                    o_fault_led_clear,
    output logic                    o_delay_a_busy,
    output logic                    o_delay_b_busy
);

    logic [GEAR_W-1:0] r_servo_divider;
    logic              r_in_valid;
    t_tick_in          r_item;
    logic              r_out_valid;
    t_fault_status     r_fault;
    t_servo_status     r_servo;

    t_fault_status     fault_status;
    t_servo_status     servo_status;
    logic              advance;

    assign advance    = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_servo_divider <= RESET_DIVIDER;
        end else if (i_cfg_we) begin
            r_servo_divider <= i_cfg_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_item.servo_enable      <= i_servo_enable;
            r_item.fault_pin_high    <= i_fault_pin_high;
            r_item.overcurrent_event <= i_overcurrent_event;
            r_item.cmd_count         <= i_cmd_count;
            r_item.encoder_count     <= i_encoder_count;
            r_item.delay_a_load      <= i_delay_a_load;
            r_item.delay_b_load      <= i_delay_b_load;
            r_item.delay_load_value  <= i_delay_load_value;
        end
    end

    ssup_fault_timers u_fault_timers (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_adv    (advance),
        .i_item   (r_item),
        .o_status (fault_status)
    );

    ssup_servo_step u_servo_step (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_adv     (advance),
        .i_item    (r_item),
        .i_divider (r_servo_divider),
        .o_status  (servo_status)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_fault <= fault_status;
            r_servo <= servo_status;
        end
    end

    assign o_out_valid         = r_out_valid;
    assign o_servo_tick        = r_servo.servo_tick;
    assign o_resynced          = r_servo.resynced;
    assign o_servo_active      = r_servo.servo_active;
    assign o_command_position  = $signed(r_servo.command_position);
    assign o_feedback_position = $signed(r_servo.feedback_position);
    assign o_overcurrent_flag  = r_fault.overcurrent_flag;
    assign o_fault_led_clear   = r_fault.fault_led_clear;
    assign o_delay_a_busy      = r_fault.delay_a_busy;
    assign o_delay_b_busy      = r_fault.delay_b_busy;

`ifndef SYNTHESIS
    a_resync_on_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_resynced |-> o_servo_tick && o_servo_active)
        else $error("resync reported without an enabled servo step");

    a_drain_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_ready && !advance |=> !o_out_valid)
        else $error("result still offered after its transfer");

    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> r_in_valid && o_out_valid && !i_out_ready)
        else $error("input stalled without a blocked result");
`endif

endmodule
